>>> rtl/core/quaternion_rotate_and_multiply_macros.svh
// Assertion macros used by the quaternion rotate and multiply checker.
`ifndef QUATERNION_ROTATE_AND_MULTIPLY_MACROS_SVH
`define QUATERNION_ROTATE_AND_MULTIPLY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define QRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/qrm_pkg.sv
// Types, constants and fixed-point helpers of the quaternion rotate and multiply unit.
package qrm_pkg;

    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 31;
    localparam int FRONT_LAT = 9;
    localparam int SIDE_LEN  = SQ_STEPS + DIV_STEPS;
    localparam int LAT       = FRONT_LAT + SQ_STEPS + DIV_STEPS + 1;
    localparam int MS_W      = 30;
    localparam int SUM_W     = 62;
    localparam int ROOT_W    = 31;
    localparam int QUO_W     = DIV_STEPS;
    localparam int DIV_NW    = 2 * MS_W;

    localparam logic KIND_ROTATE   = 1'b0;
    localparam logic KIND_MULTIPLY = 1'b1;

    typedef logic signed [31:0] t_word;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [33:0] t_rp;
    typedef logic signed [35:0] t_p;
    typedef logic signed [39:0] t_acc;

    typedef struct packed {
        logic                  kind;
        logic [2:0][31:0]      rot;
        logic [3:0]            neg;
        logic [3:0][MS_W-1:0]  ms;
        logic                  zero;
    } t_side;

    function automatic t_rp round_q30(input t_prod p);
        logic [63:0] mag;
        logic [63:0] r;
        mag = p[63] ? 64'(-p) : 64'(p);
        r   = (mag + 64'h0000_0000_2000_0000) >> 30;
        return p[63] ? -t_rp'(r[33:0]) : t_rp'(r[33:0]);
    endfunction

    function automatic t_word sat32(input t_acc v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

>>> rtl/core/quaternion_rotate_and_multiply.sv
// Top level of the quaternion rotate and multiply pipeline.
// Takes one item per cycle while not stalled and presents each result from
// the last of 72 register stages. The front end (input register, 32x32 products, rounding,
// matrix or product sums, scaling and the sum of squares) spans nine stages, the floor square
// root of the multiply path another 31 and the four normalizing dividers 31 more, one bit per
// stage, then the output register. All stages advance together: input is taken whenever the
// output register is empty or its result is being read, and while a result waits at the
// output the whole pipeline and the input hold.
module quaternion_rotate_and_multiply (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_kind,
    input  qrm_pkg::t_word i_att_w,
    input  qrm_pkg::t_word i_att_x,
    input  qrm_pkg::t_word i_att_y,
    input  qrm_pkg::t_word i_att_z,
    input  qrm_pkg::t_word i_op_w,
    input  qrm_pkg::t_word i_op_x,
    input  qrm_pkg::t_word i_op_y,
    input  qrm_pkg::t_word i_op_z,
    output logic           o_valid,
    input  logic           i_ready,
    output qrm_pkg::t_word o_res_w,
    output qrm_pkg::t_word o_res_x,
    output qrm_pkg::t_word o_res_y,
    output qrm_pkg::t_word o_res_z,
    output logic           o_degenerate
);
    import qrm_pkg::*;

    logic              en;
    logic [LAT-1:0]    r_vld;

    logic              r1_kind;
    t_word             r1_a [4];
    t_word             r1_q [4];

    logic              r2_kind;
    t_prod             r2_aa [10];
    t_prod             r2_aq [4][4];
    t_word             r2_v  [3];

    logic              r3_kind;
    t_rp               r3_aa [10];
    t_rp               r3_aq [4][4];
    t_word             r3_v  [3];

    logic              r4_kind;
    t_word             r4_r [9];
    t_p                r4_p [4];
    t_word             r4_v [3];

    logic              r5_kind;
    t_prod             r5_rv  [9];
    logic [35:0]       r5_m   [4];
    logic [3:0]        r5_neg;

    logic              r6_kind;
    t_rp               r6_rv  [9];
    logic [35:0]       r6_m   [4];
    logic [3:0]        r6_sh;
    logic [3:0]        r6_neg;

    logic              r7_kind;
    t_word             r7_rot [3];
    logic [MS_W-1:0]   r7_ms  [4];
    logic [3:0]        r7_neg;

    logic              r8_kind;
    t_word             r8_rot [3];
    logic [2*MS_W-1:0] r8_sq  [4];
    logic [MS_W-1:0]   r8_ms  [4];
    logic [3:0]        r8_neg;

    logic              r9_kind;
    t_word             r9_rot [3];
    logic [SUM_W-1:0]  r9_sum;
    logic [MS_W-1:0]   r9_ms  [4];
    logic [3:0]        r9_neg;

    t_side             n_side;
    t_side             r_side [SIDE_LEN];

    logic [ROOT_W-1:0] root;
    logic [QUO_W-1:0]  quo [4];

    t_acc              n_mat [9];
    t_acc              n_p   [4];
    logic [35:0]       n_mx;
    logic [3:0]        n_sh;

    t_word             r_res_w;
    t_word             r_res_x;
    t_word             r_res_y;
    t_word             r_res_z;
    logic              r_degen;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_comb begin
        n_mat[0] = t_acc'(r3_aa[0]) + t_acc'(r3_aa[1]) - t_acc'(r3_aa[2]) - t_acc'(r3_aa[3]);
        n_mat[1] = (t_acc'(r3_aa[4]) - t_acc'(r3_aa[9])) <<< 1;
        n_mat[2] = (t_acc'(r3_aa[5]) + t_acc'(r3_aa[8])) <<< 1;
        n_mat[3] = (t_acc'(r3_aa[4]) + t_acc'(r3_aa[9])) <<< 1;
        n_mat[4] = t_acc'(r3_aa[0]) - t_acc'(r3_aa[1]) + t_acc'(r3_aa[2]) - t_acc'(r3_aa[3]);
        n_mat[5] = (t_acc'(r3_aa[6]) - t_acc'(r3_aa[7])) <<< 1;
        n_mat[6] = (t_acc'(r3_aa[5]) - t_acc'(r3_aa[8])) <<< 1;
        n_mat[7] = (t_acc'(r3_aa[6]) + t_acc'(r3_aa[7])) <<< 1;
        n_mat[8] = t_acc'(r3_aa[0]) - t_acc'(r3_aa[1]) - t_acc'(r3_aa[2]) + t_acc'(r3_aa[3]);
        n_p[0] = t_acc'(r3_aq[0][0]) - t_acc'(r3_aq[1][1])
               - t_acc'(r3_aq[2][2]) - t_acc'(r3_aq[3][3]);
        n_p[1] = t_acc'(r3_aq[1][0]) + t_acc'(r3_aq[0][1])
               + t_acc'(r3_aq[3][2]) - t_acc'(r3_aq[2][3]);
        n_p[2] = t_acc'(r3_aq[2][0]) - t_acc'(r3_aq[3][1])
               + t_acc'(r3_aq[0][2]) + t_acc'(r3_aq[1][3]);
        n_p[3] = t_acc'(r3_aq[3][0]) + t_acc'(r3_aq[2][1])
               - t_acc'(r3_aq[1][2]) + t_acc'(r3_aq[0][3]);
    end

    always_comb begin
        n_mx = r5_m[0];
        for (int i = 1; i < 4; i++) begin
            if (r5_m[i] > n_mx) begin
                n_mx = r5_m[i];
            end
        end
        n_sh = 4'd8;
        for (int s = 8; s >= 0; s--) begin
            if ((n_mx >> s) < (36'd1 << 30)) begin
                n_sh = 4'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= i_kind;
            r1_a[0] <= i_att_w;
            r1_a[1] <= i_att_x;
            r1_a[2] <= i_att_y;
            r1_a[3] <= i_att_z;
            r1_q[0] <= i_op_w;
            r1_q[1] <= i_op_x;
            r1_q[2] <= i_op_y;
            r1_q[3] <= i_op_z;

            r2_kind  <= r1_kind;
            r2_aa[0] <= r1_a[0] * r1_a[0];
            r2_aa[1] <= r1_a[1] * r1_a[1];
            r2_aa[2] <= r1_a[2] * r1_a[2];
            r2_aa[3] <= r1_a[3] * r1_a[3];
            r2_aa[4] <= r1_a[1] * r1_a[2];
            r2_aa[5] <= r1_a[1] * r1_a[3];
            r2_aa[6] <= r1_a[2] * r1_a[3];
            r2_aa[7] <= r1_a[0] * r1_a[1];
            r2_aa[8] <= r1_a[0] * r1_a[2];
            r2_aa[9] <= r1_a[0] * r1_a[3];
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r2_aq[i][j] <= r1_a[i] * r1_q[j];
                end
            end
            for (int j = 0; j < 3; j++) begin
                r2_v[j] <= r1_q[j+1];
            end

            r3_kind <= r2_kind;
            for (int k = 0; k < 10; k++) begin
                r3_aa[k] <= round_q30(r2_aa[k]);
            end
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r3_aq[i][j] <= round_q30(r2_aq[i][j]);
                end
            end
            r3_v <= r2_v;

            r4_kind <= r3_kind;
            for (int k = 0; k < 9; k++) begin
                r4_r[k] <= sat32(n_mat[k]);
            end
            for (int i = 0; i < 4; i++) begin
                r4_p[i] <= n_p[i][35:0];
            end
            r4_v <= r3_v;

            r5_kind <= r4_kind;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r5_rv[3*i+j] <= r4_r[3*i+j] * r4_v[j];
                end
            end
            for (int i = 0; i < 4; i++) begin
                r5_m[i]   <= r4_p[i][35] ? 36'(-r4_p[i]) : 36'(r4_p[i]);
                r5_neg[i] <= r4_p[i][35];
            end

            r6_kind <= r5_kind;
            for (int k = 0; k < 9; k++) begin
                r6_rv[k] <= round_q30(r5_rv[k]);
            end
            r6_m   <= r5_m;
            r6_sh  <= n_sh;
            r6_neg <= r5_neg;

            r7_kind <= r6_kind;
            for (int i = 0; i < 3; i++) begin
                r7_rot[i] <= sat32(t_acc'(r6_rv[3*i]) + t_acc'(r6_rv[3*i+1])
                                   + t_acc'(r6_rv[3*i+2]));
            end
            for (int i = 0; i < 4; i++) begin
                r7_ms[i] <= MS_W'(r6_m[i] >> r6_sh);
            end
            r7_neg <= r6_neg;

            r8_kind <= r7_kind;
            r8_rot  <= r7_rot;
            for (int i = 0; i < 4; i++) begin
                r8_sq[i] <= (2*MS_W)'(r7_ms[i]) * (2*MS_W)'(r7_ms[i]);
            end
            r8_ms  <= r7_ms;
            r8_neg <= r7_neg;

            r9_kind <= r8_kind;
            r9_rot  <= r8_rot;
            r9_sum  <= SUM_W'(r8_sq[0]) + SUM_W'(r8_sq[1])
                     + SUM_W'(r8_sq[2]) + SUM_W'(r8_sq[3]);
            r9_ms   <= r8_ms;
            r9_neg  <= r8_neg;
        end
    end

    always_comb begin
        n_side.kind = r9_kind;
        for (int i = 0; i < 3; i++) begin
            n_side.rot[i] = r9_rot[i];
        end
        n_side.neg = r9_neg;
        for (int i = 0; i < 4; i++) begin
            n_side.ms[i] = r9_ms[i];
        end
        n_side.zero = (r9_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    qrm_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r9_sum),
        .o_root (root)
    );

    for (genvar i = 0; i < 4; i++) begin : g_div
        qrm_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ({r_side[SQ_STEPS-1].ms[i], root[ROOT_W-1:1]}),
            .i_den (root),
            .o_quo (quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_side[SIDE_LEN-1].kind == KIND_ROTATE) begin
                r_res_w <= '0;
                r_res_x <= r_side[SIDE_LEN-1].rot[0];
                r_res_y <= r_side[SIDE_LEN-1].rot[1];
                r_res_z <= r_side[SIDE_LEN-1].rot[2];
                r_degen <= 1'b0;
            end else if (r_side[SIDE_LEN-1].zero) begin
                r_res_w <= '0;
                r_res_x <= '0;
                r_res_y <= '0;
                r_res_z <= '0;
                r_degen <= 1'b1;
            end else begin
                r_res_w <= r_side[SIDE_LEN-1].neg[0] ? -t_word'({1'b0, quo[0]})
                                                     :  t_word'({1'b0, quo[0]});
                r_res_x <= r_side[SIDE_LEN-1].neg[1] ? -t_word'({1'b0, quo[1]})
                                                     :  t_word'({1'b0, quo[1]});
                r_res_y <= r_side[SIDE_LEN-1].neg[2] ? -t_word'({1'b0, quo[2]})
                                                     :  t_word'({1'b0, quo[2]});
                r_res_z <= r_side[SIDE_LEN-1].neg[3] ? -t_word'({1'b0, quo[3]})
                                                     :  t_word'({1'b0, quo[3]});
                r_degen <= 1'b0;
            end
        end
    end

    assign o_res_w      = r_res_w;
    assign o_res_x      = r_res_x;
    assign o_res_y      = r_res_y;
    assign o_res_z      = r_res_z;
    assign o_degenerate = r_degen;

endmodule

>>> rtl/core/qrm_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module qrm_isqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [qrm_pkg::SUM_W-1:0]  i_val,
    output logic [qrm_pkg::ROOT_W-1:0] o_root
);
    import qrm_pkg::*;

    logic [SUM_W-1:0] r_v   [SQ_STEPS];
    logic [SUM_W:0]   r_res [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_stage
        localparam logic [SUM_W:0] BITJ = (SUM_W+1)'(1) << (SUM_W - 2 - 2 * j);
        logic [SUM_W-1:0] v_i;
        logic [SUM_W:0]   res_i;
        logic [SUM_W:0]   t;
        if (j == 0) begin : g_first
            assign v_i   = i_val;
            assign res_i = '0;
        end else begin : g_next
            assign v_i   = r_v[j-1];
            assign res_i = r_res[j-1];
        end
        assign t = res_i + BITJ;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, v_i} >= t) begin
                    r_v[j]   <= v_i - t[SUM_W-1:0];
                    r_res[j] <= (res_i >> 1) + BITJ;
                end else begin
                    r_v[j]   <= v_i;
                    r_res[j] <= res_i >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQ_STEPS-1][ROOT_W-1:0];

endmodule

>>> rtl/core/qrm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module qrm_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [qrm_pkg::DIV_NW-1:0] i_num,
    input  logic [qrm_pkg::ROOT_W-1:0] i_den,
    output logic [qrm_pkg::QUO_W-1:0]  o_quo
);
    import qrm_pkg::*;

    logic [ROOT_W-1:0] r_rem [DIV_STEPS];
    logic [QUO_W-1:0]  r_low [DIV_STEPS];
    logic [QUO_W-1:0]  r_quo [DIV_STEPS];
    logic [ROOT_W-1:0] r_den [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
        logic [ROOT_W-1:0] rem_i;
        logic [ROOT_W-1:0] den_i;
        logic [QUO_W-1:0]  low_i;
        logic [QUO_W-1:0]  quo_i;
        logic [ROOT_W:0]   t;
        logic [ROOT_W:0]   diff;
        if (j == 0) begin : g_first
            assign rem_i = ROOT_W'(i_num[DIV_NW-1:QUO_W]);
            assign low_i = i_num[QUO_W-1:0];
            assign den_i = i_den;
            assign quo_i = '0;
        end else begin : g_next
            assign rem_i = r_rem[j-1];
            assign low_i = r_low[j-1];
            assign den_i = r_den[j-1];
            assign quo_i = r_quo[j-1];
        end
        assign t    = {rem_i, low_i[QUO_W-1]};
        assign diff = t - {1'b0, den_i};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= den_i;
                r_low[j] <= {low_i[QUO_W-2:0], 1'b0};
                if (t >= {1'b0, den_i}) begin
                    r_rem[j] <= diff[ROOT_W-1:0];
                    r_quo[j] <= {quo_i[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[j] <= t[ROOT_W-1:0];
                    r_quo[j] <= {quo_i[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

>>> rtl/core/qrm_checker.sv
// Port-level checks of the quaternion rotate and multiply unit, bound to its top level.
`include "quaternion_rotate_and_multiply_macros.svh"

module qrm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input qrm_pkg::t_word o_res_w,
    input qrm_pkg::t_word o_res_x,
    input qrm_pkg::t_word o_res_y,
    input qrm_pkg::t_word o_res_z,
    input logic           o_degenerate
);
    import qrm_pkg::*;

    `QRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid,
        "result dropped while stalled")
    `QRM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready,
        $stable(o_res_w) && $stable(o_res_x) && $stable(o_res_y) && $stable(o_res_z)
        && $stable(o_degenerate), "result changed while stalled")
    `QRM_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready,
        "input blocked with empty output")
    `QRM_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate,
        o_res_w == 0 && o_res_x == 0 && o_res_y == 0 && o_res_z == 0,
        "degenerate result not zero")

endmodule

bind quaternion_rotate_and_multiply qrm_checker u_qrm_checker (.*);
